/* rtl/bmt_pkg.sv */
// Shared constants and codes for the breakpoint match table.
`default_nettype none
package bmt_pkg;

  localparam int SLOTS_DEFAULT     = 16;
  localparam int ADDR_BITS_DEFAULT = 32;
  localparam int IN_ADDR_W         = 32;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 2;
  localparam int USED_W            = 5;

  typedef enum logic [OP_W-1:0] {
    OP_SET      = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_CHECK    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage
`default_nettype wire

/* rtl/breakpoint_match_table_unit.sv */
// Breakpoint address table with set, clear and check operations.
// Each operation passes through the input register and then the result register.
// One operation per cycle unless stalled; compare and compaction are combinational.
// A full result register under stall holds off the input register, then the input.
// Reset (rst, synchronous) empties the table and drops any pending items.
// Slot contents are not reset; only slots below the count are ever compared.
`default_nettype none
module breakpoint_match_table_unit
  import bmt_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEFAULT,
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      op,
  input  wire logic [IN_ADDR_W-1:0] address,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic                      hit,
  output logic [USED_W-1:0]         entries_used
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  // input register
  logic                 s1_valid;
  op_t                  s1_op;
  logic [ADDR_BITS-1:0] s1_addr;

  // table state
  logic [ADDR_BITS-1:0] slot [SLOTS];
  logic [CNT_W-1:0]     count;

  logic [ADDR_BITS+IN_ADDR_W-1:0] addr_ext;
  logic                           res_free;
  logic                           advance;
  logic [SLOTS-1:0]               match;
  logic [SLOTS-1:0]               first;
  logic [SLOTS-1:0]               shift_mask;
  logic                           any_match;
  logic                           full;
  logic                           do_set;
  logic                           do_clear;
  logic [CNT_W-1:0]               count_next;
  logic [ADDR_BITS-1:0]           slot_up [SLOTS];
  status_t                        status_next;
  logic                           hit_next;
  logic [CNT_W+USED_W-1:0]        used_ext;

  assign addr_ext = (ADDR_BITS + IN_ADDR_W)'(address);

  assign res_free = !out_valid || !out_stall;
  assign advance  = s1_valid && res_free;
  assign in_stall = s1_valid && !res_free;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (CNT_W'(i) < count) && (slot[i] == s1_addr);
    end
  end

  assign any_match  = |match;
  assign first      = match & (~match + SLOTS'(1));
  assign shift_mask = ~(first - SLOTS'(1));
  assign full       = (count == CNT_W'(SLOTS));
  assign do_set     = advance && (s1_op == OP_SET) && !full;
  assign do_clear   = advance && (s1_op == OP_CLEAR) && any_match;

  for (genvar g = 0; g < SLOTS; g++) begin : g_up
    if (g < SLOTS - 1) begin : g_mid
      assign slot_up[g] = slot[g+1];
    end else begin : g_last
      assign slot_up[g] = slot[g];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    hit_next    = 1'b0;
    case (s1_op)
      OP_SET: begin
        if (full) status_next = ST_FULL;
        else count_next = count + CNT_W'(1);
      end
      OP_CLEAR: begin
        if (any_match) count_next = count - CNT_W'(1);
        else status_next = ST_NOT_FOUND;
      end
      OP_CHECK: hit_next = any_match;
      default: ;
    endcase
  end

  assign used_ext = (CNT_W + USED_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (res_free) out_valid <= s1_valid;
      if (advance) count <= count_next;
    end
    if (in_valid && !in_stall) begin
      s1_op   <= op_t'(op);
      s1_addr <= addr_ext[ADDR_BITS-1:0];
    end
    if (advance) begin
      status       <= status_next;
      hit          <= hit_next;
      entries_used <= used_ext[USED_W-1:0];
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (do_set && (count == CNT_W'(i))) slot[i] <= s1_addr;
      else if (do_clear && shift_mask[i]) slot[i] <= slot_up[i];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("slot count above table size");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_full_nochange: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == OP_SET && full) |=> (count == $past(count)))
    else $error("set on full table changed the count");

  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("first-match vector not one-hot");

  a_notfound_nochange: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == OP_CLEAR && !any_match) |=> $stable(count))
    else $error("clear without match changed the count");

endmodule
`default_nettype wire
